### src/jbs_pkg.sv
// Shared types, field widths and codes for the batch job scheduler.
`default_nettype none
package jbs_pkg;

   // field widths of the item interfaces
   localparam int JOB_ID_W = 8;
   localparam int SUBMIT_W = 11;
   localparam int RUN_W    = 10;
   localparam int TIME_W   = 17;
   localparam int WT_W     = 25;
   localparam int TSUM_W   = 23;
   localparam int WSUM_W   = 31;
   localparam int POLICY_W = 2;

   // saturation limits
   localparam logic [31:0] WT_MAX   = 32'h01FF_FFFF;
   localparam logic [31:0] WSUM_MAX = 32'h7FFF_FFFF;

   // policy codes
   localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
   localparam logic [POLICY_W-1:0] POL_SJF  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_HRRN = 2'd2;

   // one stored job; done is cleared when the job is loaded
   typedef struct packed {
      logic [JOB_ID_W-1:0] id;
      logic [SUBMIT_W-1:0] submit;
      logic [RUN_W-1:0]    run;
      logic                done;
   } job_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P1_RD,
      ST_P1_CHK,
      ST_P2_RD,
      ST_P2_MUL,
      ST_P2_CMP,
      ST_CALC,
      ST_DIV
   } state_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
   } div_sts_type;

endpackage
`default_nettype wire

### src/jbs_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module jbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/jbs_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none
module jbs_div #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 10
) (
   input  wire                         clock,
   input  wire                         reset,
   input  jbs_pkg::div_ctl_type        ctl,
   input  wire [DIVIDEND_W-1:0]        dividend,
   input  wire [DIVISOR_W-1:0]         divisor,
   output jbs_pkg::div_sts_type        sts,
   output logic [DIVIDEND_W-1:0]       quotient
);
   import jbs_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;

   // one restoring step
   always_comb begin
      trial   = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (ctl.start) begin
         dvs_ff <= divisor;
      end
   end

   assign sts.done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### src/batch_job_scheduler.sv
// Non-preemptive batch scheduler (FCFS, SJF, HRRN) with a job table in RAM.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall job id, submit minute, run time, last
//   rsp      out        rsp_valid/rsp_stall schedule times, turnaround, totals, last
//   csr      in         csr_valid/csr_ready policy
//
// Items are loaded while idle; the item marked last starts dispatching.
// Each dispatch costs two scans of the job table (one RAM read per entry)
// plus a run of the bit-serial divider that forms the weighted turnaround.
// Reset is synchronous; it empties the table and sets the policy to FCFS.
// req_stall stays high while a batch is dispatched; a stalled result holds
// the sequencer only when the next result is ready to load.
`default_nettype none
module batch_job_scheduler #(
   parameter int MAX_JOBS  = 64,
   parameter int FRAC_BITS = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [jbs_pkg::JOB_ID_W-1:0]      req_job_id,
   input  wire [jbs_pkg::SUBMIT_W-1:0]      req_submit_minute,
   input  wire [jbs_pkg::RUN_W-1:0]         req_run_minutes,
   input  wire                              req_last_job,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [jbs_pkg::JOB_ID_W-1:0]     rsp_job_id_out,
   output logic [jbs_pkg::TIME_W-1:0]       rsp_start_time,
   output logic [jbs_pkg::TIME_W-1:0]       rsp_finish_time,
   output logic [jbs_pkg::TIME_W-1:0]       rsp_wait_time,
   output logic [jbs_pkg::TIME_W-1:0]       rsp_turnaround,
   output logic [jbs_pkg::WT_W-1:0]         rsp_weighted_turnaround,
   output logic [jbs_pkg::TSUM_W-1:0]       rsp_total_turnaround,
   output logic [jbs_pkg::WSUM_W-1:0]       rsp_total_weighted,
   output logic                             rsp_last_result,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [jbs_pkg::POLICY_W-1:0]      csr_policy
);
   import jbs_pkg::*;

   localparam int IW      = $clog2(MAX_JOBS);
   localparam int CW      = $clog2(MAX_JOBS + 1);
   localparam int DW      = TIME_W + FRAC_BITS;
   localparam int RATIO_W = TIME_W + 1;
   localparam int PROD_W  = RATIO_W + RUN_W;

   // control state
   state_type             state_ff, state_in;
   logic [POLICY_W-1:0]   policy_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         disp_ff;
   logic                  any_ff, found_ff;
   logic                  best_valid_ff;
   logic                  rsp_valid_ff;

   // datapath registers
   logic [TIME_W-1:0]     clock_ff;
   logic [SUBMIT_W-1:0]   earl_ff;
   job_type               best_ff, cand_ff;
   logic [IW-1:0]         best_idx_ff;
   logic                  cand_ok_ff;
   logic [PROD_W-1:0]     lhs_ff, rhs_ff;
   logic [TIME_W-1:0]     start_ff, finish_ff, wait_ff, turn_ff;
   logic [TSUM_W-1:0]     tsum_ff;
   logic [WSUM_W-1:0]     wsum_ff;

   // output registers
   logic [JOB_ID_W-1:0]   o_id_ff;
   logic [TIME_W-1:0]     o_start_ff, o_finish_ff, o_wait_ff, o_turn_ff;
   logic [WT_W-1:0]       o_wt_ff;
   logic [TSUM_W-1:0]     o_tsum_ff;
   logic [WSUM_W-1:0]     o_wsum_ff;
   logic                  o_last_ff;

   // RAM and divider connections
   logic                  ram_we;
   logic [IW-1:0]         ram_wr_addr;
   logic [IW-1:0]         ram_rd_addr;
   logic [$bits(job_type)-1:0] ram_q_raw;
   job_type               ram_q, ram_wd;
   div_ctl_type           div_ctl;
   div_sts_type           div_sts;
   logic [DW-1:0]         div_q;

   // combinational helpers
   logic                  req_acc, table_full, idx_last, out_free;
   logic                  p1_hit, p1_arr, p1_found, p1_any;
   logic [SUBMIT_W-1:0]   p1_earl;
   logic [RATIO_W-1:0]    rc, rb;
   logic                  better;
   logic [TIME_W-1:0]     c_finish, c_wait, c_turn;
   logic [31:0]           wt_ext;
   logic [WT_W-1:0]       wt_sat;
   logic [31:0]           wsum_ext;
   logic [WSUM_W-1:0]     wsum_sat;
   logic                  emit, batch_last;
   logic [RUN_W-1:0]      run_fix;

   assign req_acc    = req_valid && !req_stall;
   assign table_full = (count_ff == CW'(MAX_JOBS));
   assign idx_last   = (idx_ff + 1'b1 == count_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign ram_q      = job_type'(ram_q_raw);
   assign run_fix    = (req_run_minutes == '0) ? RUN_W'(1) : req_run_minutes;

   // job table, done marks included
   jbs_ram #(
      .WIDTH($bits(job_type)),
      .DEPTH(MAX_JOBS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wd),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_q_raw)
   );

   // weighted turnaround divider
   jbs_div #(
      .DIVIDEND_W(DW),
      .DIVISOR_W (RUN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .dividend({c_turn, FRAC_BITS'(0)}),
      .divisor (best_ff.run),
      .sts     (div_sts),
      .quotient(div_q)
   );

   // first pass: arrival and earliest pending submit
   always_comb begin
      p1_hit   = !ram_q.done;
      p1_arr   = p1_hit && (TIME_W'(ram_q.submit) <= clock_ff);
      p1_found = found_ff || p1_hit;
      p1_any   = any_ff || p1_arr;
      p1_earl  = earl_ff;
      if (p1_hit && (!found_ff || ram_q.submit < earl_ff)) begin
         p1_earl = ram_q.submit;
      end
   end

   // response ratio terms for the cross-multiplication
   assign rc = RATIO_W'(clock_ff) - RATIO_W'(ram_q.submit) + RATIO_W'(ram_q.run);
   assign rb = RATIO_W'(clock_ff) - RATIO_W'(best_ff.submit) + RATIO_W'(best_ff.run);

   // candidate preferred over current best
   always_comb begin
      better = 1'b0;
      case (policy_ff)
         POL_SJF: begin
            if (cand_ff.run != best_ff.run) begin
               better = cand_ff.run < best_ff.run;
            end else begin
               better = cand_ff.submit < best_ff.submit;
            end
         end
         POL_HRRN: begin
            if (lhs_ff != rhs_ff) begin
               better = lhs_ff > rhs_ff;
            end else begin
               better = cand_ff.submit < best_ff.submit;
            end
         end
         default: begin
            better = cand_ff.submit < best_ff.submit;
         end
      endcase
   end

   // dispatch times of the chosen job
   assign c_finish = clock_ff + TIME_W'(best_ff.run);
   assign c_wait   = clock_ff - TIME_W'(best_ff.submit);
   assign c_turn   = c_finish - TIME_W'(best_ff.submit);

   // saturation of weighted turnaround and its sum
   always_comb begin
      wt_ext   = 32'(div_q);
      wt_sat   = (wt_ext > WT_MAX) ? WT_MAX[WT_W-1:0] : wt_ext[WT_W-1:0];
      wsum_ext = 32'(wsum_ff) + 32'(wt_sat);
      wsum_sat = (wsum_ext > WSUM_MAX) ? WSUM_MAX[WSUM_W-1:0] : wsum_ext[WSUM_W-1:0];
   end

   assign batch_last = (disp_ff + 1'b1 == count_ff);
   assign emit       = (state_ff == ST_DIV) && div_sts.done && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_last_job) begin
               state_in = ST_P1_RD;
            end
         end
         ST_P1_RD: begin
            state_in = ST_P1_CHK;
         end
         ST_P1_CHK: begin
            if (!idx_last) begin
               state_in = ST_P1_RD;
            end else if (p1_found) begin
               state_in = ST_P2_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_P2_RD: begin
            state_in = ST_P2_MUL;
         end
         ST_P2_MUL: begin
            state_in = ST_P2_CMP;
         end
         ST_P2_CMP: begin
            state_in = idx_last ? ST_CALC : ST_P2_RD;
         end
         ST_CALC: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (emit) begin
               state_in = batch_last ? ST_IDLE : ST_P1_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs; loading writes a fresh entry, dispatch sets its done mark
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      ram_we        = 1'b0;
      ram_wr_addr   = count_ff[IW-1:0];
      ram_wd        = '{id: req_job_id, submit: req_submit_minute, run: run_fix,
                        done: 1'b0};
      ram_rd_addr   = idx_ff[IW-1:0];
      div_ctl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_we = req_valid && !table_full;
         end
         ST_CALC: begin
            div_ctl.start = 1'b1;
            ram_we        = 1'b1;
            ram_wr_addr   = best_idx_ff;
            ram_wd        = '{id: best_ff.id, submit: best_ff.submit, run: best_ff.run,
                              done: 1'b1};
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POL_FCFS;
         count_ff      <= '0;
         idx_ff        <= '0;
         disp_ff       <= '0;
         any_ff        <= 1'b0;
         found_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         clock_ff      <= '0;
         tsum_ff       <= '0;
         wsum_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            policy_ff <= csr_policy;
         end
         // result register: loaded on emit, freed when taken
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && !table_full) begin
                  count_ff <= count_ff + 1'b1;
               end
               idx_ff   <= '0;
               any_ff   <= 1'b0;
               found_ff <= 1'b0;
            end
            ST_P1_CHK: begin
               any_ff   <= p1_any;
               found_ff <= p1_found;
               earl_ff  <= p1_earl;
               if (idx_last) begin
                  idx_ff        <= '0;
                  best_valid_ff <= 1'b0;
                  if (!p1_found) begin
                     count_ff <= '0;
                     disp_ff  <= '0;
                     clock_ff <= '0;
                     tsum_ff  <= '0;
                     wsum_ff  <= '0;
                  end else if (!p1_any) begin
                     clock_ff <= TIME_W'(p1_earl);
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_P2_MUL: begin
               cand_ff    <= ram_q;
               cand_ok_ff <= !ram_q.done && (TIME_W'(ram_q.submit) <= clock_ff);
               lhs_ff     <= rc * PROD_W'(best_ff.run);
               rhs_ff     <= rb * PROD_W'(ram_q.run);
            end
            ST_P2_CMP: begin
               if (cand_ok_ff && (!best_valid_ff || better)) begin
                  best_ff       <= cand_ff;
                  best_idx_ff   <= idx_ff[IW-1:0];
                  best_valid_ff <= 1'b1;
               end
               idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
            end
            ST_CALC: begin
               start_ff  <= clock_ff;
               finish_ff <= c_finish;
               wait_ff   <= c_wait;
               turn_ff   <= c_turn;
               tsum_ff   <= tsum_ff + TSUM_W'(c_turn);
               clock_ff  <= c_finish;
            end
            ST_DIV: begin
               if (emit) begin
                  o_id_ff      <= best_ff.id;
                  o_start_ff   <= start_ff;
                  o_finish_ff  <= finish_ff;
                  o_wait_ff    <= wait_ff;
                  o_turn_ff    <= turn_ff;
                  o_wt_ff      <= wt_sat;
                  o_tsum_ff    <= tsum_ff;
                  o_wsum_ff    <= wsum_sat;
                  o_last_ff    <= batch_last;
                  idx_ff       <= '0;
                  any_ff       <= 1'b0;
                  found_ff     <= 1'b0;
                  if (batch_last) begin
                     count_ff <= '0;
                     disp_ff  <= '0;
                     clock_ff <= '0;
                     tsum_ff  <= '0;
                     wsum_ff  <= '0;
                  end else begin
                     disp_ff <= disp_ff + 1'b1;
                     wsum_ff <= wsum_sat;
                  end
               end
            end
            default: begin
               idx_ff <= idx_ff;
            end
         endcase
      end
   end

   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_job_id_out          = o_id_ff;
   assign rsp_start_time          = o_start_ff;
   assign rsp_finish_time         = o_finish_ff;
   assign rsp_wait_time           = o_wait_ff;
   assign rsp_turnaround          = o_turn_ff;
   assign rsp_weighted_turnaround = o_wt_ff;
   assign rsp_total_turnaround    = o_tsum_ff;
   assign rsp_total_weighted      = o_wsum_ff;
   assign rsp_last_result         = o_last_ff;

`ifndef NO_ASSERTIONS
   // the chosen job was still pending
   a_best_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> !best_ff.done && best_valid_ff)
      else $error("dispatched job already done");

   // turnaround minus wait equals the run span
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turnaround - rsp_wait_time) == (rsp_finish_time - rsp_start_time))
      else $error("inconsistent result times");

   // table never overfills
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_JOBS))
      else $error("job count beyond table depth");

   // a result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten");
`endif
endmodule
`default_nettype wire
